// ===== rtl/sqd_pkg.sv =====
// ---------------------------------------------------------------------------
// sqd_pkg
// Shared sizes and types of the shortest queue dispatcher.
// ---------------------------------------------------------------------------
package sqd_pkg;

  localparam int MAX_LINES    = 8;
  localparam int LINE_SLOTS   = 16;
  localparam int LINE_W       = $clog2(MAX_LINES);
  localparam int PTR_W        = $clog2(LINE_SLOTS);
  localparam int OCC_W        = $clog2(LINE_SLOTS + 1);

  localparam logic [1:0] REG_ACTIVE_LINES  = 2'd0;
  localparam logic [1:0] REG_LINE_CAPACITY = 2'd1;
  localparam logic [1:0] REG_CLOSE_MINUTE  = 2'd2;

  typedef struct packed {
    logic [3:0]       active_lines;
    logic [OCC_W-1:0] eff_cap;
    logic [9:0]       close_minute;
  } sqd_cfg_t;

  typedef struct packed {
    logic              rel;
    logic [10:0]       rel_t;
    logic              place;
    logic [LINE_W-1:0] place_sel;
    logic [10:0]       place_fin;
  } sqd_cmd_t;

  typedef struct packed {
    logic              pick_vld;
    logic [OCC_W-1:0]  pick_free;
    logic [LINE_W-1:0] pick_sel;
    logic [10:0]       pick_start;
    logic              adv_vld;
    logic [10:0]       adv_t;
    logic              rel_any;
  } sqd_scan_t;

endpackage

// ===== rtl/sqd_cell.sv =====
// ---------------------------------------------------------------------------
// sqd_cell
// One service line: its queue of finish times, occupancy and last finish,
// plus one step of the pick, advance and release scans along the row.
// ---------------------------------------------------------------------------
module sqd_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sqd_pkg::LINE_W-1:0]  line_id,
  input  sqd_pkg::sqd_cfg_t           cfg,
  input  sqd_pkg::sqd_cmd_t           cmd,
  input  sqd_pkg::sqd_scan_t          scan_in,
  output sqd_pkg::sqd_scan_t          scan_out
);

  logic [10:0]                fifo_r [sqd_pkg::LINE_SLOTS];
  logic [10:0]                last_r, last_nxt;
  logic [sqd_pkg::OCC_W-1:0]  occ_r, occ_nxt;
  logic [sqd_pkg::PTR_W-1:0]  head_r, head_nxt;
  logic [sqd_pkg::PTR_W-1:0]  tail_r, tail_nxt;
  logic [10:0]                head_val;
  logic [sqd_pkg::OCC_W-1:0]  free_slots;
  logic                       is_active, is_open, pop, push, pick_take, adv_take;

  assign head_val   = fifo_r[head_r];
  assign is_active  = ({{(6-sqd_pkg::LINE_W){1'b0}}, line_id} < {2'b00, cfg.active_lines});
  assign is_open    = (last_r < {1'b0, cfg.close_minute});
  assign free_slots = (cfg.eff_cap > occ_r) ? cfg.eff_cap - occ_r : '0;
  assign pop        = cmd.rel && (occ_r != '0) && (head_val == cmd.rel_t);
  assign push       = cmd.place && (cmd.place_sel == line_id);
  assign pick_take  = is_active && is_open && (free_slots > scan_in.pick_free);
  assign adv_take   = (occ_r != '0) && (head_val < {1'b0, cfg.close_minute}) &&
                      (!scan_in.adv_vld || (head_val < scan_in.adv_t));

  always_comb begin
    scan_out = scan_in;
    if (pick_take) begin
      scan_out.pick_vld   = 1'b1;
      scan_out.pick_free  = free_slots;
      scan_out.pick_sel   = line_id;
      scan_out.pick_start = last_r;
    end
    if (adv_take) begin
      scan_out.adv_vld = 1'b1;
      scan_out.adv_t   = head_val;
    end
    scan_out.rel_any = scan_in.rel_any | pop;
  end

  always_comb begin
    last_nxt = last_r;
    occ_nxt  = occ_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (pop) begin
      head_nxt = head_r + 1'b1;
      occ_nxt  = occ_r - 1'b1;
    end else if (push) begin
      tail_nxt = tail_r + 1'b1;
      occ_nxt  = occ_r + 1'b1;
      last_nxt = cmd.place_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      occ_r  <= '0;
      head_r <= '0;
      tail_r <= '0;
    end else begin
      last_r <= last_nxt;
      occ_r  <= occ_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[tail_r] <= cmd.place_fin;
    end
  end

endmodule

// ===== rtl/shortest_queue_dispatcher_top.sv =====
// ---------------------------------------------------------------------------
// shortest_queue_dispatcher_top
// Join-the-shortest-queue dispatcher over a row of service line cells.
// ---------------------------------------------------------------------------
// Each input word carries one job's service time; each output word tells
// whether the job was served, the line it joined and its start and finish.
// Input: in_tdata[9:0] service_minutes. Output: out_tuser served, out_tdata
// line_index, start_minute, finish_minute, finish_hour, finish_min_of_hour.
// One job is handled at a time. Acceptance moves the job into the pick state;
// if no line takes it, each clock advance goes through the release state,
// which pops the head jobs finishing at the new minute from all lines at once
// until none is popped, then returns to the pick state. If no line takes it
// and no advance is left, the job is turned away. The hour split is made in
// the divide and output states; a new job is taken once the output state ends.
// The row of cells is scanned combinationally.
// A finished word waits in the output register while the receiver stalls; the
// next job is accepted meanwhile but its result waits for that register.
// Reset empties all lines and loads 1 line, capacity 1 and closing at 540.
// Configuration is written through cfg_we, cfg_index and cfg_data.
// ---------------------------------------------------------------------------
module shortest_queue_dispatcher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] service_minutes
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // [0] served
  output logic [39:0] out_tdata   // line_index, start_minute, finish_minute,
                                  // finish_hour, finish_min_of_hour
);

  typedef enum logic [2:0] {S_IDLE, S_PICK, S_REL, S_DIV, S_OUT} state_t;

  state_t                     state_r;
  logic [3:0]                 active_r;
  logic [4:0]                 cap_r;
  logic [9:0]                 close_r;
  logic [9:0]                 svc_r;
  logic [10:0]                t_r;
  logic                       served_r;
  logic [sqd_pkg::LINE_W-1:0] sel_r;
  logic [9:0]                 start_r;
  logic [10:0]                fin_r;
  logic [5:0]                 q_r;
  logic                       out_valid_r;
  logic                       out_served_r;
  logic [39:0]                out_data_r;

  sqd_pkg::sqd_cfg_t          cfg;
  sqd_pkg::sqd_cmd_t          cmd;
  sqd_pkg::sqd_scan_t         chain [sqd_pkg::MAX_LINES+1];
  sqd_pkg::sqd_scan_t         res;
  logic [6:0]                 cap_ext;
  logic [10:0]                fin_now;
  logic [22:0]                q_prod;
  logic [11:0]                rem;
  logic                       in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign cap_ext = {2'b00, cap_r};
  assign cfg.active_lines = active_r;
  assign cfg.eff_cap = (cap_ext > 7'(sqd_pkg::LINE_SLOTS)) ?
                       sqd_pkg::OCC_W'(sqd_pkg::LINE_SLOTS) : sqd_pkg::OCC_W'(cap_ext);
  assign cfg.close_minute = close_r;

  assign chain[0] = '0;
  assign res      = chain[sqd_pkg::MAX_LINES];
  assign fin_now  = res.pick_start + {1'b0, svc_r};

  assign cmd.rel       = (state_r == S_REL);
  assign cmd.rel_t     = t_r;
  assign cmd.place     = (state_r == S_PICK) && res.pick_vld;
  assign cmd.place_sel = res.pick_sel;
  assign cmd.place_fin = fin_now;

  genvar g;
  generate
    for (g = 0; g < sqd_pkg::MAX_LINES; g++) begin : g_cell
      sqd_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .line_id (sqd_pkg::LINE_W'(g)),
        .cfg     (cfg),
        .cmd     (cmd),
        .scan_in (chain[g]),
        .scan_out(chain[g+1])
      );
    end
  endgenerate

  assign q_prod = 23'(fin_r) * 23'd2185;
  assign rem    = {1'b0, fin_r} - ({q_r, 6'b0} - {4'b0, q_r, 2'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 4'd1;
      cap_r    <= 5'd1;
      close_r  <= 10'd540;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sqd_pkg::REG_ACTIVE_LINES:  active_r <= cfg_data[3:0];
        sqd_pkg::REG_LINE_CAPACITY: cap_r    <= cfg_data[4:0];
        sqd_pkg::REG_CLOSE_MINUTE:  close_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            svc_r   <= in_tdata[9:0];
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (res.pick_vld) begin
            served_r <= 1'b1;
            sel_r    <= res.pick_sel;
            start_r  <= res.pick_start[9:0];
            fin_r    <= fin_now;
            state_r  <= S_DIV;
          end else if (res.adv_vld) begin
            t_r     <= res.adv_t;
            state_r <= S_REL;
          end else begin
            served_r <= 1'b0;
            sel_r    <= '0;
            start_r  <= '0;
            fin_r    <= '0;
            state_r  <= S_DIV;
          end
        end
        S_REL: begin
          if (!res.rel_any) begin
            state_r <= S_PICK;
          end
        end
        S_DIV: begin
          q_r     <= q_prod[22:17];
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_served_r <= served_r;
            if (served_r) begin
              out_data_r <= {4'b0, rem[5:0], q_r + 6'd8, fin_r, start_r, 3'(sel_r)};
            end else begin
              out_data_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_served_r;
  assign out_tdata  = out_data_r;

  a_turned_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("turned-away word carries data");

  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[35:30] < 6'd60))
    else $error("minute of hour out of range");

  a_accept_pick: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_PICK))
    else $error("accepted job not scanned");

  a_pick_free: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PICK) && res.pick_vld) |-> (res.pick_free != '0))
    else $error("job placed on a full line");

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the shortest queue dispatcher.
// ---------------------------------------------------------------------------
// Jobs are streamed through the input channel with random gaps while the
// result channel stalls at random, including one long hold-off that fills
// the block. A queue-model predictor keeps its own simulated clock, line
// FIFOs and settings and computes every result word, which is compared field
// by field with the block's output. A short directed table of jobs comes
// first, then phases of random jobs under several settings.
// ---------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic        served;
    logic [2:0]  line_index;
    logic [9:0]  start_minute;
    logic [10:0] finish_minute;
    logic [5:0]  finish_hour;
    logic [5:0]  finish_min_of_hour;
  } job_result_t;

  typedef struct {
    logic [9:0]  svc;
    logic        known;
    job_result_t res;
  } job_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        out_tuser;
  logic [39:0] out_tdata;

  shortest_queue_dispatcher_top u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tuser(out_tuser), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  int unsigned lines_set, cap_set, close_set;
  int unsigned sim_clock;
  int unsigned last_fin [sqd_pkg::MAX_LINES];
  int unsigned occ [sqd_pkg::MAX_LINES];
  int unsigned head [sqd_pkg::MAX_LINES];
  int unsigned tail [sqd_pkg::MAX_LINES];
  int unsigned fin_fifo [sqd_pkg::MAX_LINES*sqd_pkg::LINE_SLOTS];

  job_result_t pending_results[$];
  int          errors = 0;
  int          mismatches = 0;
  int          jobs_sent = 0;
  int          served_seen = 0;
  int          turned_seen = 0;
  bit          long_hold = 1'b0;

  function automatic int pick_line();
    int unsigned n, cap, best, fr;
    int sel;
    n = (lines_set > sqd_pkg::MAX_LINES) ? sqd_pkg::MAX_LINES : lines_set;
    cap = (cap_set > sqd_pkg::LINE_SLOTS) ? sqd_pkg::LINE_SLOTS : cap_set;
    best = 0;
    sel = -1;
    for (int l = 0; l < n; l++) begin
      fr = (cap > occ[l]) ? cap - occ[l] : 0;
      if (last_fin[l] < close_set && fr > best) begin
        best = fr;
        sel = l;
      end
    end
    return sel;
  endfunction

  function automatic bit advance_clock();
    int unsigned t, h;
    bit found;
    t = 0;
    found = 1'b0;
    for (int l = 0; l < sqd_pkg::MAX_LINES; l++) begin
      if (occ[l] > 0) begin
        h = fin_fifo[l*sqd_pkg::LINE_SLOTS + head[l]];
        if (h < close_set && (!found || h < t)) begin
          t = h;
          found = 1'b1;
        end
      end
    end
    if (!found) return 1'b0;
    sim_clock = t & 10'h3ff;
    for (int l = 0; l < sqd_pkg::MAX_LINES; l++) begin
      while (occ[l] > 0 && fin_fifo[l*sqd_pkg::LINE_SLOTS + head[l]] == t) begin
        head[l] = (head[l] + 1) % sqd_pkg::LINE_SLOTS;
        occ[l]--;
      end
    end
    return 1'b1;
  endfunction

  function automatic job_result_t dispatch_job(logic [9:0] svc);
    job_result_t r;
    int sel;
    int unsigned st, fin;
    r = '0;
    sel = pick_line();
    for (int i = 0; sel < 0 && i <= sqd_pkg::MAX_LINES*sqd_pkg::LINE_SLOTS; i++) begin
      if (!advance_clock()) break;
      sel = pick_line();
    end
    if (sel < 0) return r;
    st = last_fin[sel];
    fin = (st + svc) & 11'h7ff;
    fin_fifo[sel*sqd_pkg::LINE_SLOTS + tail[sel]] = fin;
    tail[sel] = (tail[sel] + 1) % sqd_pkg::LINE_SLOTS;
    occ[sel]++;
    last_fin[sel] = fin;
    r.served = 1'b1;
    r.line_index = 3'(sel);
    r.start_minute = 10'(st);
    r.finish_minute = 11'(fin);
    r.finish_hour = 6'(8 + fin / 60);
    r.finish_min_of_hour = 6'(fin % 60);
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sqd_pkg::REG_ACTIVE_LINES) lines_set = {28'd0, val[3:0]};
    else if (idx == sqd_pkg::REG_LINE_CAPACITY) cap_set = {27'd0, val[4:0]};
    else if (idx == sqd_pkg::REG_CLOSE_MINUTE) close_set = {22'd0, val};
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_lines(int unsigned n, int unsigned cap, int unsigned cl);
    wait_idle();
    write_reg(sqd_pkg::REG_ACTIVE_LINES, 10'(n));
    write_reg(sqd_pkg::REG_LINE_CAPACITY, 10'(cap));
    write_reg(sqd_pkg::REG_CLOSE_MINUTE, 10'(cl));
  endtask

  // A known expectation from the table is checked against the predicted one,
  // which is always the word queued, so a wrong predictor is caught as well.
  task automatic send_job(logic [9:0] svc, bit known, job_result_t want);
    job_result_t r;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, svc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = dispatch_job(svc);
    if (known && r != want) begin
      errors++;
      $display("directed row for %0d minutes: table %h, predictor %h", svc, want, r);
    end
    pending_results.insert(pending_results.size(), r);
    jobs_sent++;
  endtask

  always @(posedge clk) begin
    job_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[2:0], out_tdata[12:3], out_tdata[23:13],
             out_tdata[29:24], out_tdata[35:30]};
      if (pending_results.size() == 0) begin
        errors++;
        $display("unexpected result word %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.served) served_seen++; else turned_seen++;
        if (got != want || out_tdata[39:36] != 4'd0) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: served %0d/%0d line %0d/%0d start %0d/%0d ",
                      "fin %0d/%0d hour %0d/%0d min %0d/%0d (expected/actual)"},
                     want.served, got.served, want.line_index, got.line_index,
                     want.start_minute, got.start_minute, want.finish_minute,
                     got.finish_minute, want.finish_hour, got.finish_hour,
                     want.finish_min_of_hour, got.finish_min_of_hour);
        end
      end
    end
  end

  // Receiver: random stalls, with stall-free stretches and one long hold-off.
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      w = ((jobs_sent / 150) % 3 == 0) ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  job_row_t dir_rows[$];

  initial begin
    int unsigned mode;
    lines_set = 1; cap_set = 1; close_set = 540;
    sim_clock = 0;
    for (int l = 0; l < sqd_pkg::MAX_LINES; l++) begin
      last_fin[l] = 0; occ[l] = 0; head[l] = 0; tail[l] = 0;
    end
    for (int i = 0; i < sqd_pkg::MAX_LINES*sqd_pkg::LINE_SLOTS; i++) fin_fifo[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one line of one slot closing at 540.
    dir_rows = '{
      '{10'd1, 1'b1, '{1'b1, 3'd0, 10'd0, 11'd1, 6'd8, 6'd1}},
      '{10'd1023, 1'b1, '{1'b1, 3'd0, 10'd1, 11'd1024, 6'd25, 6'd4}},
      '{10'd5, 1'b1, '{1'b0, 3'd0, 10'd0, 11'd0, 6'd0, 6'd0}},
      '{10'd0, 1'b0, '0},
      '{10'd682, 1'b0, '0},
      '{10'd341, 1'b0, '0}
    };
    foreach (dir_rows[i]) send_job(dir_rows[i].svc, dir_rows[i].known, dir_rows[i].res);

    // Zero lines, zero capacity and zero close minute turn every job away.
    set_lines(0, 4, 540);
    send_job(10'd7, 1'b1, '0);
    set_lines(4, 0, 540);
    send_job(10'd7, 1'b1, '0);
    set_lines(4, 4, 0);
    send_job(10'd7, 1'b1, '0);
    // Out-of-range lines and capacity are clamped; same-length jobs tie.
    set_lines(15, 31, 1023);
    for (int i = 0; i < 10; i++) send_job(10'd60, 1'b0, '0);
    send_job(10'd0, 1'b0, '0);
    // Capacity lowered below occupancy, with a short close.
    set_lines(8, 1, 1);
    for (int i = 0; i < 4; i++) send_job(10'd1, 1'b0, '0);

    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: set_lines(1, 1, 540);
        1: set_lines(8, 16, 1023);
        2: set_lines(3, 4, 540);
        3: set_lines(8, 16, 1);
        default: set_lines($urandom_range(0, 15), $urandom_range(0, 31),
                           $urandom_range(0, 1023));
      endcase
      if (ph == 5) long_hold = 1'b1;
      for (int i = 0; i < 150; i++) begin
        mode = $urandom_range(0, 9);
        if (mode < 6) send_job(10'($urandom_range(1, 90)), 1'b0, '0);
        else if (mode < 8) send_job(10'($urandom_range(0, 1023)), 1'b0, '0);
        else if (mode == 8) send_job(10'd0, 1'b0, '0);
        else send_job({1'($urandom_range(0, 1)), 9'h1ff}, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Ran %0d jobs over eleven settings phases: %0d served, %0d turned away.",
             jobs_sent, served_seen, turned_seen);
    if (errors == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sqd_pkg.sv
rtl/sqd_cell.sv
rtl/shortest_queue_dispatcher_top.sv
sim/tb.sv
